// ===== hw/rtl/assert_macros.svh =====
// Concurrent assertion helpers, clocked and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_CLK(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`define ASSERT_NEVER(name, clk, rst_n, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(name, clk, rst_n, prop)

`define ASSERT_NEVER(name, clk, rst_n, expr)

`endif

`endif

// ===== hw/rtl/krla_pkg.sv =====
`default_nettype none

package krla_pkg;

  localparam logic [4:0] KEY_TYPE   = 5'd1;
  localparam logic [9:0] KEY_PLUS   = 10'd115;
  localparam logic [9:0] KEY_MINUS  = 10'd114;
  localparam logic [9:0] KEY_SELECT = 10'd54;
  localparam logic [9:0] KEY_START  = 10'd28;
  localparam logic [9:0] KEY_DOWN   = 10'd38;
  localparam logic [9:0] KEY_UP     = 10'd19;

  localparam logic [15:0] DELAY_RST    = 16'd300;
  localparam logic [15:0] INTERVAL_RST = 16'd100;
  localparam logic [3:0]  BTOP_RST     = 4'd10;
  localparam logic [4:0]  VTOP_RST     = 5'd20;

  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    REG_DELAY    = 2'd0,
    REG_INTERVAL = 2'd1,
    REG_BTOP     = 2'd2,
    REG_VTOP     = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] repeat_delay_ms;
    logic [15:0] repeat_interval_ms;
    logic [3:0]  brightness_top;
    logic [4:0]  volume_top;
  } krla_cfg_t;

  typedef struct packed {
    logic        mode;
    logic [4:0]  event_type;
    logic [9:0]  key_code;
    logic [1:0]  key_value;
    logic [31:0] now_ms;
  } krla_item_t;

  typedef struct packed {
    logic       volume_reapply;
    logic       volume_changed;
    logic       brightness_changed;
    logic [4:0] volume_level;
    logic [3:0] brightness_level;
  } krla_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/key_repeat_level_adjuster_unit.sv =====
`default_nettype none

// Key auto-repeat level adjuster. Takes one item per clock when the result is not
// stalled. Items pass an input register, then a single pass of compares and 32-bit
// adds that updates the key state and levels and loads the result register.
// Throughput is one item per cycle while results are taken; a stalled result
// holds the input register, which still takes an item if the result is taken.
// s_axis_tuser carries the mode (0 key event, 1 poll tick). Configuration writes
// are always ready and take effect on the next cycle.
module key_repeat_level_adjuster_unit
  import krla_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // event_type[4:0], key_code[14:5], key_value[16:15], now_ms[48:17], zero fill
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // mode
  input  wire logic                  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // brightness_level[3:0], volume_level[8:4], brightness_changed[9],
  // volume_changed[10], volume_reapply[11], zero fill
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [1:0]            cfg_addr_i,
  input  wire logic [15:0]           cfg_data_i
);

  krla_cfg_t    cfg;
  krla_item_t   in_item, stage_item;
  krla_result_t result;
  logic         stage_valid;
  logic         advance;

  assign cfg_ready_o = 1'b1;

  assign in_item.mode       = s_axis_tuser;
  assign in_item.event_type = s_axis_tdata[4:0];
  assign in_item.key_code   = s_axis_tdata[14:5];
  assign in_item.key_value  = s_axis_tdata[16:15];
  assign in_item.now_ms     = s_axis_tdata[48:17];

  krla_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  krla_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  krla_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .valid_i     (stage_valid),
    .item_i      (stage_item),
    .advance_o   (advance),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (result)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - $bits(krla_result_t)){1'b0}}, result};

endmodule

`default_nettype wire

// ===== hw/rtl/krla_cfg.sv =====
`default_nettype none

module krla_cfg
  import krla_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [15:0] cfg_data_i,
  output krla_cfg_t        cfg_o
);

  krla_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_DELAY:    cfg_d.repeat_delay_ms    = cfg_data_i;
        REG_INTERVAL: cfg_d.repeat_interval_ms = cfg_data_i;
        REG_BTOP:     cfg_d.brightness_top     = cfg_data_i[3:0];
        REG_VTOP:     cfg_d.volume_top         = cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.repeat_delay_ms    <= DELAY_RST;
      cfg_q.repeat_interval_ms <= INTERVAL_RST;
      cfg_q.brightness_top     <= BTOP_RST;
      cfg_q.volume_top         <= VTOP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/krla_in_stage.sv =====
`default_nettype none

module krla_in_stage
  import krla_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire krla_item_t in_item_i,
  input  wire logic       advance_i,
  output logic            valid_o,
  output krla_item_t      item_o
);

  logic       valid_q, valid_d;
  krla_item_t item_q;

  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ===== hw/rtl/krla_core.sv =====
`default_nettype none
`include "assert_macros.svh"

module krla_core
  import krla_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire krla_cfg_t  cfg_i,
  input  wire logic       valid_i,
  input  wire krla_item_t item_i,
  output logic            advance_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output krla_result_t    result_o
);

  logic        start_held_q, start_held_d;
  logic        select_held_q, select_held_d;
  logic        up_held_q, up_held_d;
  logic        up_fresh_q, up_fresh_d;
  logic [31:0] up_due_q, up_due_d;
  logic        down_held_q, down_held_d;
  logic        down_fresh_q, down_fresh_d;
  logic [31:0] down_due_q, down_due_d;
  logic [3:0]  bright_q, bright_d, bright_mid;
  logic [4:0]  vol_q, vol_d, vol_mid;
  logic        out_valid_q, out_valid_d;
  krla_result_t res_q, res_d;

  logic        pressed;
  logic        reapply;
  logic        up_serve, down_serve;
  logic [31:0] up_diff, down_diff;
  logic [31:0] press_due;

  assign advance_o = valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    start_held_d  = start_held_q;
    select_held_d = select_held_q;
    up_held_d     = up_held_q;
    up_fresh_d    = up_fresh_q;
    up_due_d      = up_due_q;
    down_held_d   = down_held_q;
    down_fresh_d  = down_fresh_q;
    down_due_d    = down_due_q;
    bright_mid    = bright_q;
    vol_mid       = vol_q;
    bright_d      = bright_q;
    vol_d         = vol_q;
    reapply       = 1'b0;

    pressed    = |item_i.key_value;
    press_due  = item_i.now_ms + {16'd0, cfg_i.repeat_delay_ms};
    up_diff    = item_i.now_ms - up_due_q;
    down_diff  = item_i.now_ms - down_due_q;
    up_serve   = item_i.mode && (up_fresh_q || (up_held_q && !up_diff[31]));
    down_serve = item_i.mode && (down_fresh_q || (down_held_q && !down_diff[31]));

    if (!item_i.mode) begin
      if (item_i.event_type == KEY_TYPE) begin
        case (item_i.key_code)
          KEY_START:  start_held_d  = pressed;
          KEY_SELECT: select_held_d = pressed;
          KEY_UP: begin
            up_held_d  = pressed;
            up_fresh_d = pressed;
            if (pressed) begin
              up_due_d = press_due;
            end
          end
          KEY_DOWN: begin
            down_held_d  = pressed;
            down_fresh_d = pressed;
            if (pressed) begin
              down_due_d = press_due;
            end
          end
          KEY_PLUS, KEY_MINUS: reapply = 1'b1;
          default: ;
        endcase
      end
    end

    // up first, then down on the stepped level
    if (up_serve) begin
      if (start_held_q) begin
        if (bright_q < cfg_i.brightness_top) begin
          bright_mid = bright_q + 4'd1;
        end
      end else if (select_held_q) begin
        if (vol_q < cfg_i.volume_top) begin
          vol_mid = vol_q + 5'd1;
        end
      end
      if (up_fresh_q) begin
        up_fresh_d = 1'b0;
      end else begin
        up_due_d = up_due_q + {16'd0, cfg_i.repeat_interval_ms};
      end
    end

    bright_d = bright_mid;
    vol_d    = vol_mid;
    if (down_serve) begin
      if (start_held_q) begin
        if (bright_mid != 4'd0) begin
          bright_d = bright_mid - 4'd1;
        end
      end else if (select_held_q) begin
        if (vol_mid != 5'd0) begin
          vol_d = vol_mid - 5'd1;
        end
      end
      if (down_fresh_q) begin
        down_fresh_d = 1'b0;
      end else begin
        down_due_d = down_due_q + {16'd0, cfg_i.repeat_interval_ms};
      end
    end

    res_d.brightness_level   = bright_d;
    res_d.volume_level       = vol_d;
    res_d.brightness_changed = bright_d != bright_q;
    res_d.volume_changed     = vol_d != vol_q;
    res_d.volume_reapply     = reapply;

    out_valid_d = out_valid_q;
    if (advance_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_held_q  <= 1'b0;
      select_held_q <= 1'b0;
      up_held_q     <= 1'b0;
      up_fresh_q    <= 1'b0;
      up_due_q      <= 32'd0;
      down_held_q   <= 1'b0;
      down_fresh_q  <= 1'b0;
      down_due_q    <= 32'd0;
      bright_q      <= 4'd0;
      vol_q         <= 5'd0;
      out_valid_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance_o) begin
        start_held_q  <= start_held_d;
        select_held_q <= select_held_d;
        up_held_q     <= up_held_d;
        up_fresh_q    <= up_fresh_d;
        up_due_q      <= up_due_d;
        down_held_q   <= down_held_d;
        down_fresh_q  <= down_fresh_d;
        down_due_q    <= down_due_d;
        bright_q      <= bright_d;
        vol_q         <= vol_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  `ASSERT_CLK(a_key_no_change, clk_i, rst_ni,
    advance_o && !item_i.mode |=> !res_q.brightness_changed && !res_q.volume_changed)
  `ASSERT_CLK(a_tick_no_reapply, clk_i, rst_ni,
    advance_o && item_i.mode |=> !res_q.volume_reapply)
  `ASSERT_CLK(a_level_matches, clk_i, rst_ni,
    advance_o |=> res_q.brightness_level == bright_q && res_q.volume_level == vol_q)
  `ASSERT_CLK(a_fresh_needs_held, clk_i, rst_ni,
    up_fresh_q |-> up_held_q)
  `ASSERT_NEVER(a_down_fresh_unheld, clk_i, rst_ni, down_fresh_q && !down_held_q)

endmodule

`default_nettype wire

// ===== sim/tb_key_repeat_level_adjuster_unit.sv =====
`default_nettype none

module tb_key_repeat_level_adjuster_unit
  import krla_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [1:0]            cfg_addr_i = '0;
  logic [15:0]           cfg_data_i = '0;

  key_repeat_level_adjuster_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  krla_item_t   event_q[$];
  krla_result_t level_q[$];
  krla_item_t   drv_item;
  krla_result_t drv_res;
  int unsigned  src_idle_pct = 0;
  int unsigned  snk_stall_pct = 0;
  int unsigned  err_cnt = 0;
  logic [31:0]  now_t;

  logic [15:0] dly_ms = DELAY_RST;
  logic [15:0] intv_ms = INTERVAL_RST;
  logic [3:0]  btop = BTOP_RST;
  logic [4:0]  vtop = VTOP_RST;

  logic        start_on = 1'b0;
  logic        select_on = 1'b0;
  logic        up_on = 1'b0;
  logic        up_new = 1'b0;
  logic [31:0] up_due = '0;
  logic        down_on = 1'b0;
  logic        down_new = 1'b0;
  logic [31:0] down_due = '0;
  logic [3:0]  bri = '0;
  logic [4:0]  vol = '0;

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= 40) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic step_level(input logic up);
    if (start_on) begin
      if (up) begin
        if (bri < btop) bri = bri + 4'd1;
      end else if (bri != 4'd0) begin
        bri = bri - 4'd1;
      end
    end else if (select_on) begin
      if (up) begin
        if (vol < vtop) vol = vol + 5'd1;
      end else if (vol != 5'd0) begin
        vol = vol - 5'd1;
      end
    end
  endtask

  task automatic predict_levels(input krla_item_t it, output krla_result_t res);
    logic [3:0]  b0;
    logic [4:0]  v0;
    logic        pressed;
    logic        reapply;
    logic [31:0] up_gap;
    logic [31:0] down_gap;
    b0 = bri;
    v0 = vol;
    pressed = (it.key_value != 2'd0);
    reapply = 1'b0;
    if (!it.mode) begin
      if (it.event_type == KEY_TYPE) begin
        case (it.key_code)
          KEY_START:  start_on = pressed;
          KEY_SELECT: select_on = pressed;
          KEY_UP: begin
            up_on = pressed;
            up_new = pressed;
            if (pressed) up_due = it.now_ms + {16'd0, dly_ms};
          end
          KEY_DOWN: begin
            down_on = pressed;
            down_new = pressed;
            if (pressed) down_due = it.now_ms + {16'd0, dly_ms};
          end
          KEY_PLUS, KEY_MINUS: reapply = 1'b1;
          default: ;
        endcase
      end
    end else begin
      up_gap = it.now_ms - up_due;
      if (up_new || (up_on && !up_gap[31])) begin
        step_level(1'b1);
        if (up_new) up_new = 1'b0;
        else up_due = up_due + {16'd0, intv_ms};
      end
      down_gap = it.now_ms - down_due;
      if (down_new || (down_on && !down_gap[31])) begin
        step_level(1'b0);
        if (down_new) down_new = 1'b0;
        else down_due = down_due + {16'd0, intv_ms};
      end
    end
    res.brightness_level   = bri;
    res.volume_level       = vol;
    res.brightness_changed = (bri != b0);
    res.volume_changed     = (vol != v0);
    res.volume_reapply     = reapply;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_levels(drv_item, drv_res);
        level_q.push_back(drv_res);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (event_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          drv_item = event_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {7'd0, drv_item.now_ms, drv_item.key_value,
                            drv_item.key_code, drv_item.event_type};
          s_axis_tuser  <= drv_item.mode;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    krla_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (level_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
      end else begin
        want = level_q.pop_front();
        if (m_axis_tdata[3:0] != want.brightness_level ||
            m_axis_tdata[8:4] != want.volume_level ||
            m_axis_tdata[9]   != want.brightness_changed ||
            m_axis_tdata[10]  != want.volume_changed ||
            m_axis_tdata[11]  != want.volume_reapply)
          report_mismatch($sformatf(
            "bri %0d/%0d vol %0d/%0d bchg %0b/%0b vchg %0b/%0b reapply %0b/%0b",
            m_axis_tdata[3:0], want.brightness_level,
            m_axis_tdata[8:4], want.volume_level,
            m_axis_tdata[9], want.brightness_changed,
            m_axis_tdata[10], want.volume_changed,
            m_axis_tdata[11], want.volume_reapply));
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  task automatic push_item(input logic mode, input logic [4:0] etype,
                           input logic [9:0] code, input logic [1:0] value,
                           input logic [31:0] now);
    krla_item_t it;
    it.mode       = mode;
    it.event_type = etype;
    it.key_code   = code;
    it.key_value  = value;
    it.now_ms     = now;
    event_q.push_back(it);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_DELAY:    dly_ms = val;
      REG_INTERVAL: intv_ms = val;
      REG_BTOP:     btop = val[3:0];
      REG_VTOP:     vtop = val[4:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (event_q.size() != 0 || s_axis_tvalid || level_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic push_random(input int n, input logic [31:0] tmax);
    int          r;
    logic [9:0]  code;
    logic [1:0]  value;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) now_t = now_t - $urandom_range(0, tmax);
      else if (r < 5) now_t = $urandom();
      else now_t = now_t + $urandom_range(0, tmax);
      value = 2'($urandom_range(0, 2));
      r = $urandom_range(0, 99);
      if (r < 35) begin
        push_item(1'b1, 5'($urandom_range(0, 31)), 10'($urandom_range(0, 767)),
                  value, now_t);
      end else if (r < 90) begin
        case ($urandom_range(0, 7))
          0:       code = KEY_START;
          1:       code = KEY_SELECT;
          2, 3:    code = KEY_UP;
          4, 5:    code = KEY_DOWN;
          6:       code = KEY_PLUS;
          default: code = KEY_MINUS;
        endcase
        push_item(1'b0, KEY_TYPE, code, value, now_t);
      end else begin
        push_item(1'b0, 5'($urandom_range(0, 31)), 10'($urandom_range(0, 767)),
                  value, now_t);
      end
    end
  endtask

  initial begin
    logic [31:0] tmax;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_item(1'b1, 5'd0, 10'd0, 2'd0, 32'd1000);
    push_item(1'b0, KEY_TYPE, KEY_START, 2'd1, 32'd1000);
    push_item(1'b0, KEY_TYPE, KEY_UP, 2'd1, 32'd1010);
    push_item(1'b1, 5'd0, 10'd0, 2'd0, 32'd1020);
    push_item(1'b1, 5'd0, 10'd0, 2'd0, 32'd1309);
    push_item(1'b1, 5'd0, 10'd0, 2'd0, 32'd1310);
    push_item(1'b1, 5'd0, 10'd0, 2'd0, 32'd2000);
    push_item(1'b0, KEY_TYPE, KEY_UP, 2'd0, 32'd2000);
    push_item(1'b0, KEY_TYPE, KEY_DOWN, 2'd2, 32'd2001);
    push_item(1'b0, KEY_TYPE, KEY_UP, 2'd1, 32'd2001);
    push_item(1'b1, 5'd0, 10'd0, 2'd0, 32'd2002);
    push_item(1'b0, KEY_TYPE, KEY_START, 2'd0, 32'd2003);
    push_item(1'b0, KEY_TYPE, KEY_SELECT, 2'd2, 32'd2004);
    push_item(1'b1, 5'd0, 10'd0, 2'd0, 32'd2500);
    push_item(1'b0, KEY_TYPE, KEY_PLUS, 2'd1, 32'd2501);
    push_item(1'b0, KEY_TYPE, KEY_MINUS, 2'd0, 32'd2502);
    push_item(1'b0, 5'd0, KEY_UP, 2'd1, 32'd2503);
    push_item(1'b0, KEY_TYPE, 10'd767, 2'd2, 32'd2504);
    push_item(1'b0, 5'd31, 10'd512, 2'd1, 32'd2505);
    push_item(1'b1, 5'd31, 10'd767, 2'd2, 32'hFFFF_FFFF);
    push_item(1'b1, 5'd0, 10'd0, 2'd0, 32'd2600);
    push_item(1'b0, KEY_TYPE, KEY_UP, 2'd0, 32'd2601);
    push_item(1'b0, KEY_TYPE, KEY_DOWN, 2'd0, 32'd2602);
    push_item(1'b1, 5'd0, 10'd0, 2'd0, 32'd9000);
    now_t = 32'd9000;

    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      case (ph)
        0: ;
        1: begin
          write_reg(REG_DELAY, 16'd0);
          write_reg(REG_INTERVAL, 16'd1);
          write_reg(REG_BTOP, 16'd15);
          write_reg(REG_VTOP, 16'd31);
        end
        2: begin
          write_reg(REG_DELAY, 16'hFFFF);
          write_reg(REG_INTERVAL, 16'hFFFF);
          write_reg(REG_BTOP, 16'd0);
          write_reg(REG_VTOP, 16'd0);
        end
        3: begin
          write_reg(REG_DELAY, 16'd50);
          write_reg(REG_INTERVAL, 16'd0);
          write_reg(REG_BTOP, 16'd3);
          write_reg(REG_VTOP, 16'd5);
        end
        4: begin
          write_reg(REG_DELAY, DELAY_RST);
          write_reg(REG_INTERVAL, INTERVAL_RST);
          write_reg(REG_BTOP, 16'd15);
          write_reg(REG_VTOP, 16'd31);
        end
        5: begin
          write_reg(REG_DELAY, 16'd20);
          write_reg(REG_INTERVAL, 16'd30);
          write_reg(REG_BTOP, 16'd2);
          write_reg(REG_VTOP, 16'd4);
        end
        6: begin
          write_reg(REG_DELAY, 16'd1000);
          write_reg(REG_INTERVAL, 16'd7);
          write_reg(REG_BTOP, 16'd7);
          write_reg(REG_VTOP, 16'd9);
        end
        default: begin
          write_reg(REG_DELAY, 16'($urandom_range(0, 2000)));
          write_reg(REG_INTERVAL, 16'($urandom_range(1, 500)));
          write_reg(REG_BTOP, 16'($urandom_range(0, 15)));
          write_reg(REG_VTOP, 16'($urandom_range(0, 31)));
        end
      endcase
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 52; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 52; end
        default: begin src_idle_pct = 34; snk_stall_pct = 34; end
      endcase
      tmax = ({16'd0, dly_ms} + {16'd0, intv_ms}) / 4 + 2;
      if (ph == 2 || ph == 5) now_t = 32'hFFFF_FFFF - $urandom_range(0, 20 * tmax);
      push_random(160, tmax);
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0 && level_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ===== key_repeat_level_adjuster_unit.f =====
+incdir+hw/rtl
hw/rtl/krla_pkg.sv
hw/rtl/krla_cfg.sv
hw/rtl/krla_in_stage.sv
hw/rtl/krla_core.sv
hw/rtl/key_repeat_level_adjuster_unit.sv
sim/tb_key_repeat_level_adjuster_unit.sv
